// ===== src/mlbt_pkg.sv =====
// Package for the MAC learning bridge table.
// Holds field widths, verdict codes, the controller state type and the table entry type.
// No dependencies.
package mlbt_pkg;

    localparam int unsigned PORT_W    = 4;
    localparam int unsigned MAC_W     = 48;
    localparam int unsigned VERDICT_W = 2;

    // Group bit of the first transmitted byte
    localparam int unsigned GROUP_BIT = 40;

    localparam logic [VERDICT_W-1:0] VERDICT_FLOOD   = 2'd0;
    localparam logic [VERDICT_W-1:0] VERDICT_UNICAST = 2'd1;
    localparam logic [VERDICT_W-1:0] VERDICT_DROP    = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_DONE = 3'b100
    } state_t;

    typedef struct packed {
        logic [MAC_W-1:0]  mac;
        logic [PORT_W-1:0] port;
    } entry_t;

endpackage

// ===== src/mac_learning_bridge_table.sv =====
// Top level of the MAC learning bridge table: learns source addresses into a
// table memory with one read and one write port and classifies each frame's destination.
// Depends on mlbt_pkg.
//
// One transaction on the s_ channel carries one frame header (ingress port,
// destination MAC, source MAC) and produces exactly one transaction on the m_
// channel (verdict, out_port, learn_full). The table lives in one synchronous
// memory of TABLE_DEPTH entries, each holding a MAC and its port, filled in
// order from entry 0. Entries at or above the fill count are never read, so
// the memory needs no clearing pass after reset. Per header, one linear scan
// over the filled entries looks up the source and the destination together,
// one entry per cycle through the memory's single read port with registered
// read data; the source is then learned with one write (port update on a hit,
// append on a miss while room remains). A header is accepted in the idle state,
// then scanned with one read per filled entry and a final compare of the last
// read, then learned and its result registered in the done state. A finished
// result waits in the output register, and the next header is accepted
// meanwhile; the write cycle of the following header stalls only if that
// earlier result still has not been taken.
module mac_learning_bridge_table #(
    parameter int unsigned TABLE_DEPTH = 64
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,

    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [mlbt_pkg::PORT_W-1:0]          s_in_port,
    input  logic [mlbt_pkg::MAC_W-1:0]           s_dst_mac,
    input  logic [mlbt_pkg::MAC_W-1:0]           s_src_mac,

    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [mlbt_pkg::VERDICT_W-1:0]       m_verdict,
    output logic [mlbt_pkg::PORT_W-1:0]          m_out_port,
    output logic                                 m_learn_full
);

    // Index width addresses the memory; count width also holds TABLE_DEPTH.
    localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

    // ------------------------------------------------------------------
    // Table memory: one write and one registered read per cycle
    // ------------------------------------------------------------------
    mlbt_pkg::entry_t table_mem [TABLE_DEPTH];

    logic             rd_en;
    logic [AW-1:0]    rd_idx;
    mlbt_pkg::entry_t rd_data_reg;
    logic             wr_en;
    logic [AW-1:0]    wr_idx;
    mlbt_pkg::entry_t wr_data;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            table_mem[wr_idx] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= table_mem[rd_idx];
        end
    end

    // ------------------------------------------------------------------
    // Control and working registers
    // ------------------------------------------------------------------
    mlbt_pkg::state_t state_reg, state_next;

    logic [CW-1:0]                  fill_reg, fill_next;
    logic [CW-1:0]                  addr_reg, addr_next;
    logic                           rd_vld_reg, rd_vld_next;
    logic [AW-1:0]                  rd_idx_reg, rd_idx_next;

    // Header captured at accept
    logic [mlbt_pkg::PORT_W-1:0]    port_reg, port_next;
    logic [mlbt_pkg::MAC_W-1:0]     dst_reg, dst_next;
    logic [mlbt_pkg::MAC_W-1:0]     src_reg, src_next;

    // Scan results
    logic                           src_hit_reg, src_hit_next;
    logic [AW-1:0]                  src_idx_reg, src_idx_next;
    logic                           dst_hit_reg, dst_hit_next;
    logic [mlbt_pkg::PORT_W-1:0]    dst_port_reg, dst_port_next;

    // Output register
    logic                           m_valid_reg, m_valid_next;
    logic [mlbt_pkg::VERDICT_W-1:0] verdict_reg, verdict_next;
    logic [mlbt_pkg::PORT_W-1:0]    out_port_reg, out_port_next;
    logic                           full_reg, full_next;

    logic s_fire;
    logic room;
    logic finish;

    assign s_ready = (state_reg == mlbt_pkg::ST_IDLE);
    assign s_fire  = s_valid && s_ready;
    assign room    = (fill_reg < DEPTH_C);
    // The result slot frees up this cycle or is already empty
    assign finish  = (state_reg == mlbt_pkg::ST_DONE) && (!m_valid_reg || m_ready);

    always_comb begin
        state_next    = state_reg;
        fill_next     = fill_reg;
        addr_next     = addr_reg;
        rd_vld_next   = 1'b0;
        rd_idx_next   = rd_idx_reg;
        port_next     = port_reg;
        dst_next      = dst_reg;
        src_next      = src_reg;
        src_hit_next  = src_hit_reg;
        src_idx_next  = src_idx_reg;
        dst_hit_next  = dst_hit_reg;
        dst_port_next = dst_port_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        verdict_next  = verdict_reg;
        out_port_next = out_port_reg;
        full_next     = full_reg;
        rd_en         = 1'b0;
        rd_idx        = addr_reg[AW-1:0];
        wr_en         = 1'b0;
        wr_idx        = src_idx_reg;
        wr_data.mac   = src_reg;
        wr_data.port  = port_reg;

        case (state_reg)
            mlbt_pkg::ST_IDLE: begin
                if (s_fire) begin
                    port_next    = s_in_port;
                    dst_next     = s_dst_mac;
                    src_next     = s_src_mac;
                    src_hit_next = 1'b0;
                    dst_hit_next = 1'b0;
                    addr_next    = '0;
                    state_next   = mlbt_pkg::ST_SCAN;
                end
            end

            mlbt_pkg::ST_SCAN: begin
                // Issue the next read while entries remain below the fill count
                if (addr_reg < fill_reg) begin
                    rd_en       = 1'b1;
                    rd_vld_next = 1'b1;
                    rd_idx_next = addr_reg[AW-1:0];
                    addr_next   = addr_reg + 1'b1;
                end
                // Compare the entry read in the previous cycle
                if (rd_vld_reg) begin
                    if (rd_data_reg.mac == src_reg) begin
                        src_hit_next = 1'b1;
                        src_idx_next = rd_idx_reg;
                    end
                    if (rd_data_reg.mac == dst_reg) begin
                        dst_hit_next  = 1'b1;
                        dst_port_next = rd_data_reg.port;
                    end
                end
                // Leave once no reads remain; the last compare lands this cycle
                if (!(addr_reg < fill_reg)) begin
                    state_next = mlbt_pkg::ST_DONE;
                end
            end

            mlbt_pkg::ST_DONE: begin
                if (finish) begin
                    // Learn the source: update on hit, append while room remains
                    full_next = 1'b0;
                    if (src_hit_reg) begin
                        wr_en = 1'b1;
                    end else if (room) begin
                        wr_en     = 1'b1;
                        wr_idx    = fill_reg[AW-1:0];
                        fill_next = fill_reg + 1'b1;
                    end else begin
                        full_next = 1'b1;
                    end

                    // Classify the destination; a destination equal to the
                    // source sees the port just learned, if it was stored
                    out_port_next = '0;
                    if (dst_reg[mlbt_pkg::GROUP_BIT]) begin
                        verdict_next = mlbt_pkg::VERDICT_FLOOD;
                    end else if (dst_reg == src_reg) begin
                        if (src_hit_reg || room) begin
                            verdict_next  = mlbt_pkg::VERDICT_UNICAST;
                            out_port_next = port_reg;
                        end else begin
                            verdict_next = mlbt_pkg::VERDICT_DROP;
                        end
                    end else if (dst_hit_reg) begin
                        verdict_next  = mlbt_pkg::VERDICT_UNICAST;
                        out_port_next = dst_port_reg;
                    end else begin
                        verdict_next = mlbt_pkg::VERDICT_DROP;
                    end

                    m_valid_next = 1'b1;
                    state_next   = mlbt_pkg::ST_IDLE;
                end
            end

            default: begin
                state_next = mlbt_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= mlbt_pkg::ST_IDLE;
            fill_reg    <= '0;
            rd_vld_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            fill_reg    <= fill_next;
            rd_vld_reg  <= rd_vld_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers, no reset
    always_ff @(posedge aclk) begin
        addr_reg     <= addr_next;
        rd_idx_reg   <= rd_idx_next;
        port_reg     <= port_next;
        dst_reg      <= dst_next;
        src_reg      <= src_next;
        src_hit_reg  <= src_hit_next;
        src_idx_reg  <= src_idx_next;
        dst_hit_reg  <= dst_hit_next;
        dst_port_reg <= dst_port_next;
        verdict_reg  <= verdict_next;
        out_port_reg <= out_port_next;
        full_reg     <= full_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_verdict    = verdict_reg;
    assign m_out_port   = out_port_reg;
    assign m_learn_full = full_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= DEPTH_C)
        else $error("fill count exceeds table depth");

    a_read_in_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        rd_vld_reg |-> (CW'(rd_idx_reg) < fill_reg))
        else $error("read beyond filled part of the table");

    a_full_only_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && full_reg) |-> (fill_reg == DEPTH_C))
        else $error("learn_full reported with room in the table");

    a_port_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && (verdict_reg != mlbt_pkg::VERDICT_UNICAST)) |-> (out_port_reg == '0))
        else $error("out_port nonzero on flood or drop");

    a_accept_scans: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire |=> (state_reg == mlbt_pkg::ST_SCAN))
        else $error("accepted header did not start a scan");

endmodule
